// ===== sv/osm_pkg.sv =====
// osm_pkg: request kinds and transaction types for the order statistic multiset
// used by osm_cell and order_statistic_multiset
package osm_pkg;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_ERASE  = 3'd1,
    KIND_RANK   = 3'd2,
    KIND_KTH    = 3'd3,
    KIND_PRED   = 3'd4,
    KIND_SUCC   = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] operand;
  } req_t;

  typedef struct packed {
    logic signed [31:0] answer;
    logic               found;
    logic               full_error;
  } rsp_t;

  // per-cell control broadcast from the top level
  typedef struct packed {
    logic do_insert;
    logic do_erase;
  } cell_ctl_t;

endpackage

// ===== sv/osm_cell.sv =====
// osm_cell: one slot of the sorted chain, holds a value and its valid bit
// shifts toward its upper or lower neighbor on insert and erase; uses osm_pkg
module osm_cell #(
  parameter int W = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  osm_pkg::cell_ctl_t ctl_i,
  input  logic signed [W-1:0] op_i,
  input  logic signed [W-1:0] lower_val_i,
  input  logic               lower_gt_i,
  input  logic               lower_valid_i,
  input  logic signed [W-1:0] upper_val_i,
  input  logic               upper_valid_i,
  input  logic               erase_from_i,
  output logic signed [W-1:0] val_o,
  output logic               valid_o,
  output logic               gt_o,
  output logic               lt_o,
  output logic               eq_o
);

  logic signed [W-1:0] val_q, val_d;
  logic                valid_q, valid_d;

  assign val_o   = val_q;
  assign valid_o = valid_q;
  assign gt_o    = valid_q && (val_q > op_i);
  assign lt_o    = valid_q && (val_q < op_i);
  assign eq_o    = valid_q && (val_q == op_i);

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctl_i.do_insert) begin
      if (lower_gt_i) begin
        val_d   = lower_val_i;
        valid_d = lower_valid_i;
      end else if (gt_o || (!valid_q && lower_valid_i)) begin
        val_d   = op_i;
        valid_d = 1'b1;
      end
    end else if (ctl_i.do_erase && erase_from_i) begin
      val_d   = upper_val_i;
      valid_d = upper_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== sv/order_statistic_multiset.sv =====
// order_statistic_multiset: top level, a chain of osm_cell slots kept sorted
// plus a select unit that reduces per-cell flags; uses osm_pkg and osm_cell
//
// Usage: drive req_i and pulse start_i while busy_o is low. The request is
// taken at that edge, busy_o rises, and the result appears on rsp_o with
// done_o high for one cycle. The receiver cannot stall; done_o is a strobe.
// Steps: the request is registered on accept, S_APPLY applies insert or
// erase to every cell in parallel while per-cell less-than flags and a
// one-hot pick of the answer cell are captured, and S_COUNT encodes the
// less-than boundary into a rank and muxes out the picked cell. The next
// request can be taken in the cycle done_o is high, so a new transaction
// is accepted only after the previous one completes.
// Insert moves every cell above the insertion point up by one neighbor,
// erase moves the cells above the removed copy down by one.
// Reset clears all valid bits and the count at once; stored values need no
// clearing. An insert into a full chain is dropped with full_error set.
module order_statistic_multiset #(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  osm_pkg::req_t  req_i,
  output logic           busy_o,
  output logic           done_o,
  output osm_pkg::rsp_t  rsp_o
);

  localparam int VW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {S_IDLE, S_APPLY, S_COUNT} state_e;

  state_e              state_q;
  logic [2:0]          kind_q;
  logic [31:0]         raw_q;
  logic signed [VW-1:0] op_q;
  logic [CW-1:0]       count_q;

  logic signed [VW-1:0] val   [CAPACITY];
  logic [CAPACITY-1:0]  valid, gt, lt, eq;
  logic [CAPACITY-1:0]  lt_q, hit_q, hit;
  logic [CAPACITY-1:0]  lt_up, gt_dn, kth_hit, lt_edge;
  logic [CAPACITY-1:0]  erase_from;
  osm_pkg::cell_ctl_t   ctl;
  logic                 full, present;
  logic                 kth_ok;
  logic [IW-1:0]        kth_idx;

  assign full    = (count_q == CW'(CAPACITY));
  assign present = |eq;
  assign ctl.do_insert = (state_q == S_APPLY) &&
                         (kind_q == osm_pkg::KIND_INSERT) && !full;
  assign ctl.do_erase  = (state_q == S_APPLY) &&
                         (kind_q == osm_pkg::KIND_ERASE) && present;

  // erase: every copy of the operand and every valid cell above them take their upper neighbor
  assign erase_from = eq | gt;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VW-1:0] lv, uv;
    logic lg, lvld, uvld;
    if (g == 0) begin : g_lo
      // the chain base acts as an occupied slot
      assign lv = '0; assign lg = 1'b0; assign lvld = 1'b1;
    end else begin : g_lo
      assign lv = val[g-1]; assign lg = gt[g-1]; assign lvld = valid[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi
      assign uv = '0; assign uvld = 1'b0;
    end else begin : g_hi
      assign uv = val[g+1]; assign uvld = valid[g+1];
    end
    osm_cell #(.W(VW)) u_cell (
      .clk_i, .rst_ni, .ctl_i(ctl), .op_i(op_q),
      .lower_val_i(lv), .lower_gt_i(lg), .lower_valid_i(lvld),
      .upper_val_i(uv), .upper_valid_i(uvld), .erase_from_i(erase_from[g]),
      .val_o(val[g]), .valid_o(valid[g]), .gt_o(gt[g]), .lt_o(lt[g]),
      .eq_o(eq[g])
    );
  end

  // one-hot pick of the cell that holds the answer
  assign kth_ok  = (raw_q != 32'd0) && (raw_q <= 32'(count_q));
  assign kth_idx = IW'(raw_q - 32'd1);
  assign lt_up   = {1'b0, lt[CAPACITY-1:1]};
  assign gt_dn   = {gt[CAPACITY-2:0], 1'b0};

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      kth_hit[i] = kth_ok && (kth_idx == IW'(i));
    end
  end

  always_comb begin
    case (kind_q)
      osm_pkg::KIND_KTH:  hit = kth_hit;
      osm_pkg::KIND_PRED: hit = lt & ~lt_up;
      osm_pkg::KIND_SUCC: hit = gt & ~gt_dn;
      default:            hit = '0;
    endcase
  end

  // rank from the boundary of the captured less-than flags
  logic [CW-1:0] n_lt;
  assign lt_edge = ~lt_q & {lt_q[CAPACITY-2:0], 1'b1};
  always_comb begin
    n_lt = (&lt_q) ? CW'(CAPACITY) : '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lt_edge[i]) n_lt = n_lt | CW'(i);
    end
  end

  logic signed [VW-1:0] sel_val;
  always_comb begin
    sel_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_q[i]) sel_val = sel_val | val[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      kind_q <= req_i.kind;
      raw_q  <= req_i.operand;
      op_q   <= VW'(req_i.operand);
    end
    if (state_q == S_APPLY) begin
      lt_q  <= lt;
      hit_q <= hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_o  <= 1'b0;
      rsp_o   <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start_i) state_q <= S_APPLY;
        S_APPLY: begin
          rsp_o <= '0;
          if (kind_q == osm_pkg::KIND_INSERT) begin
            if (full) rsp_o.full_error <= 1'b1;
            else begin
              rsp_o.found <= 1'b1;
              count_q     <= count_q + CW'(1);
            end
          end else if (kind_q == osm_pkg::KIND_ERASE && present) begin
            rsp_o.found <= 1'b1;
            count_q     <= count_q - CW'(1);
          end
          state_q <= S_COUNT;
        end
        S_COUNT: begin
          case (kind_q)
            osm_pkg::KIND_RANK: begin
              rsp_o.answer <= 32'(n_lt) + 32'd1;
              rsp_o.found  <= 1'b1;
            end
            osm_pkg::KIND_KTH, osm_pkg::KIND_PRED, osm_pkg::KIND_SUCC: begin
              rsp_o.answer <= 32'(sel_val);
              rsp_o.found  <= |hit_q;
            end
            default: ;
          endcase
          done_o  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY)) else $error("count over capacity");
  a_done_after_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == S_COUNT) else $error("stray done");
  a_full_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.full_error |-> !rsp_o.found) else $error("full with found");

endmodule
